// ===== rtl/chp_pkg.sv =====
// Package for the cascaded complex high-pass filter: sizes, codes and
// saturation helpers. No dependencies.
`timescale 1ns / 1ps

package chp_pkg;

  // Cascade and sample sizes
  localparam int MAX_STAGES   = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int STATE_WIDTH  = SAMPLE_WIDTH + 8;
  localparam int STAGE_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int ADDR_W       = STAGE_W + 1;
  localparam int DEPTH        = 2 * MAX_STAGES;

  // Configuration fields
  localparam int COEF_W     = 16;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Datapath widths
  localparam int DIFF_W  = STATE_WIDTH + 1;     // x - x_prev
  localparam int B0_W    = COEF_W + 2;          // signed operand holding 65536 + g
  localparam int PROD_W  = DIFF_W + B0_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SHIFT   = COEF_W + 1;          // b0 carries 2^17 scaling
  localparam int ROUND_W = ACC_W - SHIFT;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (SHIFT - 1);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE = 2'd0,
    CFG_POLE_COEF     = 2'd1,
    CFG_STAGE_COUNT   = 2'd2
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_OUT  = 5'b10000
  } seq_state_e;

  // Clamp a rounded stage value to the state word
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [ROUND_W-1:0] v
  );
    logic [ROUND_W-STATE_WIDTH:0] top;
    logic signed [STATE_WIDTH-1:0] r;
    top = v[ROUND_W-1:STATE_WIDTH-1];
    if ((top == '0) || (top == '1)) begin
      r = v[STATE_WIDTH-1:0];
    end else if (v[ROUND_W-1]) begin
      r = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp a state word to the sample width
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [STATE_WIDTH-1:0] v
  );
    logic [STATE_WIDTH-SAMPLE_WIDTH:0] top;
    logic signed [SAMPLE_WIDTH-1:0] r;
    top = v[STATE_WIDTH-1:SAMPLE_WIDTH-1];
    if ((top == '0) || (top == '1)) begin
      r = v[SAMPLE_WIDTH-1:0];
    end else if (v[STATE_WIDTH-1]) begin
      r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cascaded_complex_highpass_top.sv =====
// Cascaded complex single-pole high-pass filter, top level.
// Stage state in one synchronous memory, one shared multiplier; uses chp_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: i_sample, q_sample
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: i_result, q_result
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Filtering walks the N stages in use for each channel, three steps per stage
// and channel (difference multiply, pole multiply, add and write back), in an
// order set by the single multiplier and the memory read port. Pass-through
// goes straight to the result state. Reset clears the control, configuration
// and output valid registers and the valid bit of every memory entry at once; an entry not yet written reads as zero.
// A finished result waits in the output register while the next transaction
// is taken; the sequencer holds only if that register is still full.

module cascaded_complex_highpass_top
  import chp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample input; tdata: i_sample [15:0], q_sample [31:16]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,
  // Result output; tdata: i_result [15:0], q_result [31:16]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,
  // Register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic               enable_q;
  logic [COEF_W-1:0]  pole_q;
  logic [COUNT_W-1:0] count_q;
  logic [STAGE_W-1:0] last_stage;

  // Sequencer
  seq_state_e         state_q, state_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic               ch_q, ch_d;
  logic               s_accept;

  // Datapath registers
  logic signed [STATE_WIDTH-1:0]  x_q, x_d;
  logic signed [SAMPLE_WIDTH-1:0] q_in_q;
  logic signed [SAMPLE_WIDTH-1:0] i_res_q, i_res_d;
  logic signed [SAMPLE_WIDTH-1:0] q_res_q, q_res_d;
  logic signed [STATE_WIDTH-1:0]  yprev_q;
  logic signed [PROD_W-1:0]       prod_q, p1_q;

  // Output register
  logic        m_valid_q;
  logic [31:0] m_data_q;

  // State memory: {prev_output, prev_input} per entry, entry = {stage, channel}
  logic [2*STATE_WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]         valid_q;
  logic [2*STATE_WIDTH-1:0] rd_q;
  logic                     rd_valid_q;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     mem_we;

  // Arithmetic
  logic signed [STATE_WIDTH-1:0]  prev_in, prev_out;
  logic signed [DIFF_W-1:0]       diff, mul_a;
  logic signed [B0_W-1:0]         mul_b;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ROUND_W-1:0]      rnd;
  logic signed [STATE_WIDTH-1:0]  y;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Last stage index, with zero taken as one stage and overflow clamped
  always_comb begin
    if (count_q == '0) begin
      last_stage = '0;
    end else if (count_q > COUNT_W'(MAX_STAGES)) begin
      last_stage = STAGE_W'(MAX_STAGES - 1);
    end else begin
      last_stage = STAGE_W'(count_q - COUNT_W'(1));
    end
  end

  // Register write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      pole_q   <= '0;
      count_q  <= COUNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FILTER_ENABLE: enable_q <= cfg_data_i[0];
        CFG_POLE_COEF:     pole_q   <= cfg_data_i[COEF_W-1:0];
        CFG_STAGE_COUNT:   count_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Memory read data, zero for entries never written
  assign prev_in  = rd_valid_q ? signed'(rd_q[STATE_WIDTH-1:0]) : '0;
  assign prev_out = rd_valid_q ? signed'(rd_q[2*STATE_WIDTH-1:STATE_WIDTH]) : '0;

  // Shared multiplier: (65536 + g) * (x - x_prev), then g * y_prev
  assign diff = DIFF_W'(x_q) - DIFF_W'(prev_in);
  always_comb begin
    if (state_q == ST_MUL2) begin
      mul_a = DIFF_W'(yprev_q);
      mul_b = signed'({2'b00, pole_q});
    end else begin
      mul_a = diff;
      mul_b = signed'({1'b0, 1'b1, pole_q});
    end
  end

  // Sum, round half up, clamp to the state word
  assign acc = ACC_W'(p1_q) + (ACC_W'(prod_q) <<< 1) + ROUND_BIAS;
  assign rnd = acc[ACC_W-1:SHIFT];
  assign y   = sat_state(rnd);

  assign waddr  = {stage_q, ch_q};
  assign raddr  = {stage_d, ch_d};
  assign mem_we = (state_q == ST_ACC);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    ch_d    = ch_q;
    x_d     = x_q;
    i_res_d = i_res_q;
    q_res_d = q_res_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          stage_d = '0;
          ch_d    = 1'b0;
          x_d     = STATE_WIDTH'(signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]));
          i_res_d = s_axis_tdata[SAMPLE_WIDTH-1:0];
          q_res_d = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
          state_d = enable_q ? ST_MUL1 : ST_OUT;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_ACC;
      ST_ACC: begin
        x_d = y;
        if (stage_q == last_stage) begin
          stage_d = '0;
          if (!ch_q) begin
            i_res_d = sat_sample(y);
            ch_d    = 1'b1;
            x_d     = STATE_WIDTH'(q_in_q);
            state_d = ST_MUL1;
          end else begin
            q_res_d = sat_sample(y);
            ch_d    = 1'b0;
            state_d = ST_OUT;
          end
        end else begin
          stage_d = stage_q + STAGE_W'(1);
          state_d = ST_MUL1;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      ch_q    <= ch_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    i_res_q <= i_res_d;
    q_res_q <= q_res_d;
    prod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (s_accept) begin
      q_in_q <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
    if (state_q == ST_MUL1) begin
      yprev_q <= prev_out;
    end
    if (state_q == ST_MUL2) begin
      p1_q <= prod_q;
    end
  end

  // State memory: write back in the accumulate cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= {y, x_q};
    end
    rd_q <= mem_q[raddr];
  end

  // Entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[waddr] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr];
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {q_res_q, i_res_q};
    end
  end

`ifndef NO_ASSERTIONS
  // The stage walk never passes the last stage in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MUL1) || (state_q == ST_MUL2) || (state_q == ST_ACC))
      |-> (stage_q <= last_stage))
    else $error("stage index beyond the configured cascade");

  // A result is only presented after the sequencer has finished a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output loaded outside the result state");

  // A written entry is valid from the next cycle on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> valid_q[$past(waddr)])
    else $error("memory entry not marked valid after write back");

  // Pass-through goes straight to the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !enable_q) |=> (state_q == ST_OUT))
    else $error("pass-through transaction entered the filter walk");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for cascaded_complex_highpass_top: directed and random complex
// samples go through the stream ports and are compared with a cycle-free model of the
// cascaded high-pass in this file. Depends on chp_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import chp_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 4000;
  localparam int                   SETTLE_CYCLES  = 8;
  localparam int                   RANDOM_PHASES  = 12;
  localparam int                   PHASE_ITEMS    = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 2'd3;  // no register behind it

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] q_val;
    logic signed [SAMPLE_WIDTH-1:0] i_val;
  } iq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // i_sample [15:0], q_sample [31:16]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // i_result [15:0], q_result [31:16]
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Filter model state and registers
  logic                          hp_enable;
  logic [COEF_W-1:0]             pole_q16;
  logic [COUNT_W-1:0]            stage_cnt;
  logic signed [STATE_WIDTH-1:0] hp_prev_in [DEPTH];
  logic signed [STATE_WIDTH-1:0] hp_prev_out[DEPTH];

  iq_result_t expected_results[$];
  iq_result_t oldest_result;
  bit  src_idle_en  = 1'b1;
  bit  sink_idle_en = 1'b1;
  int  fail_count   = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  reg_writes   = 0;
  int  quiet_cycles = 0;

  cascaded_complex_highpass_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic longint clamp_to(longint v, int w);
    longint hi = (longint'(1) << (w - 1)) - 1;
    longint lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void reset_filter_model();
    hp_enable = 1'b0;
    pole_q16  = '0;
    stage_cnt = COUNT_W'(1);
    for (int k = 0; k < DEPTH; k++) begin
      hp_prev_in[k]  = '0;
      hp_prev_out[k] = '0;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FILTER_ENABLE: hp_enable = data[0];
      CFG_POLE_COEF:     pole_q16  = data[COEF_W-1:0];
      CFG_STAGE_COUNT:   stage_cnt = data[COUNT_W-1:0];
      default: ;  // drop writes to unmapped indexes
    endcase
  endfunction

  // Run one channel through the first n stages, updating their history
  function automatic longint highpass_chain(longint x, int ch, int n);
    longint d;
    longint acc;
    longint y;
    longint g;
    int     k;
    g = longint'(pole_q16);
    for (int s = 0; s < n; s++) begin
      k   = 2 * s + ch;
      d   = x - longint'(hp_prev_in[k]);
      acc = (longint'(65536) + g) * d + 2 * g * longint'(hp_prev_out[k]);
      y   = clamp_to((acc + 65536) >>> 17, STATE_WIDTH);
      hp_prev_in[k]  = STATE_WIDTH'(x);
      hp_prev_out[k] = STATE_WIDTH'(y);
      x = y;
    end
    return x;
  endfunction

  function automatic iq_result_t filter_sample(logic signed [SAMPLE_WIDTH-1:0] i_s,
                                               logic signed [SAMPLE_WIDTH-1:0] q_s);
    iq_result_t r;
    int         n;
    r.i_val = i_s;
    r.q_val = q_s;
    if (hp_enable) begin
      n = int'(stage_cnt);
      if (n < 1) n = 1;
      if (n > MAX_STAGES) n = MAX_STAGES;
      r.i_val = SAMPLE_WIDTH'(clamp_to(highpass_chain(longint'(i_s), 0, n), SAMPLE_WIDTH));
      r.q_val = SAMPLE_WIDTH'(clamp_to(highpass_chain(longint'(q_s), 1, n), SAMPLE_WIDTH));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Random back-pressure on the result side
  always @(posedge clk_i) begin
    m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= 36);
  end

  // Offer one sample, hold it until the transaction completes, then predict it
  task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] i_s,
                             logic signed [SAMPLE_WIDTH-1:0] q_s);
    while (src_idle_en && ($urandom_range(99) < 36)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q_s, i_s};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(filter_sample(i_s, q_s));
    samples_sent++;
  endtask

  // Stop offering and wait for every outstanding result, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] make_sample(int kind, int dc);
    int v;
    case (kind)
      0: v = int'($signed(SAMPLE_WIDTH'($urandom)));
      1: v = dc + $urandom_range(512) - 256;
      2: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(64) - 32;
    endcase
    return SAMPLE_WIDTH'(clamp_to(longint'(v), SAMPLE_WIDTH));
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result 0x%08h arrived with nothing outstanding", m_axis_tdata);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        results_seen++;
        if (m_axis_tdata[15:0] !== oldest_result.i_val) begin
          $error("i_result mismatch: expected %0d, actual %0d",
                 oldest_result.i_val, $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== oldest_result.q_val) begin
          $error("q_result mismatch: expected %0d, actual %0d",
                 oldest_result.q_val, $signed(m_axis_tdata[31:16]));
          fail_count++;
        end
      end
    end
  end

  // Abort when no transaction of any kind completes for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset leaves filtering off; a write to an unmapped index changes nothing
  task automatic test_passthrough_at_reset();
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, -16'sh0001);
    send_sample(16'sh5A5A, -16'sh2A5B);
  endtask

  // Largest pole with full-scale swings drives the output into saturation
  task automatic test_pole_extremes();
    write_reg(CFG_FILTER_ENABLE, 16'h0001);
    write_reg(CFG_POLE_COEF, 16'hFFFF);
    write_reg(CFG_STAGE_COUNT, 16'h0001);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    write_reg(CFG_POLE_COEF, 16'h0000);
    send_sample(16'sh1234, -16'sh1234);
    send_sample(16'sh1234, -16'sh1234);
  endtask

  // Zero stages act as one; counts past the cascade depth clamp to it
  task automatic test_stage_count_limits();
    write_reg(CFG_POLE_COEF, 16'hF000);
    write_reg(CFG_STAGE_COUNT, 16'h0000);
    send_sample(16'sh4000, -16'sh4000);
    send_sample(-16'sh7000, 16'sh3000);
    write_reg(CFG_STAGE_COUNT, 16'h000F);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
  endtask

  // Bypass returns the input and must leave the filter history alone
  task automatic test_bypass_holds_state();
    write_reg(CFG_STAGE_COUNT, 16'h0002);
    send_sample(16'sh2000, 16'sh1000);
    send_sample(16'sh2100, 16'sh0F00);
    write_reg(CFG_FILTER_ENABLE, 16'h0000);
    send_sample(-16'sh6000, 16'sh7000);
    write_reg(CFG_FILTER_ENABLE, 16'h0001);
    send_sample(16'sh2200, 16'sh0E00);
  endtask

  // Stages dropped from the cascade resume from their old history
  task automatic test_unused_stages_keep_state();
    write_reg(CFG_STAGE_COUNT, 16'h0004);
    send_sample(16'sh3000, -16'sh3000);
    send_sample(16'sh3100, -16'sh2F00);
    write_reg(CFG_STAGE_COUNT, 16'h0001);
    send_sample(-16'sh1000, 16'sh1000);
    send_sample(-16'sh1100, 16'sh1100);
    write_reg(CFG_STAGE_COUNT, 16'h0004);
    send_sample(16'sh0800, -16'sh0800);
  endtask

  // Bits above each register's width are ignored
  task automatic test_register_masking();
    write_reg(CFG_FILTER_ENABLE, 16'hFFFE);
    send_sample(16'sh1357, -16'sh2468);
    write_reg(CFG_STAGE_COUNT, 16'hFFF3);
    write_reg(CFG_FILTER_ENABLE, 16'hAAAB);
    send_sample(16'sh1357, -16'sh2468);
  endtask

  // Random settings per phase; mostly signal-like input with noise and extremes mixed in
  task automatic test_random_phases();
    int        dc_i;
    int        dc_q;
    int        pick;
    int        kind;
    logic      en;
    logic [COEF_W-1:0]  pole;
    logic [COUNT_W-1:0] stages;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      src_idle_en  = (p != 3);
      sink_idle_en = (p != 3);
      en = (p == 9) ? 1'b0 : ($urandom_range(7) != 0);
      case ($urandom_range(3))
        0: pole = '0;
        1: pole = '1;
        2: pole = COEF_W'($urandom);
        default: pole = COEF_W'($urandom_range(65535, 60000));
      endcase
      case ($urandom_range(3))
        0: stages = COUNT_W'(1);
        1: stages = COUNT_W'(MAX_STAGES);
        2: stages = COUNT_W'($urandom_range(15));
        default: stages = COUNT_W'($urandom_range(4, 1));
      endcase
      if (p == 0) begin
        pole   = '1;
        stages = COUNT_W'(MAX_STAGES);
        en     = 1'b1;
      end
      write_reg(CFG_POLE_COEF, pole);
      write_reg(CFG_STAGE_COUNT, (CFG_DATA_W'($urandom) & 16'hFFF0) | CFG_DATA_W'(stages));
      write_reg(CFG_FILTER_ENABLE, (CFG_DATA_W'($urandom) & 16'hFFFE) | CFG_DATA_W'(en));
      if ($urandom_range(3) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
      dc_i = $urandom_range(65535) - 32768;
      dc_q = $urandom_range(65535) - 32768;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once until the pipeline is empty
        if (p == 6 && n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(99);
        if (pick < 45) kind = 0;
        else if (pick < 70) kind = 1;
        else if (pick < 85) kind = 2;
        else kind = 3;
        send_sample(make_sample(kind, dc_i), make_sample(kind, dc_q));
      end
    end
    drain_results();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    reset_filter_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough_at_reset();
    test_pole_extremes();
    test_stage_count_limits();
    test_bypass_holds_state();
    test_unused_stages_keep_state();
    test_register_masking();
    test_random_phases();

    drain_results();
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Run covered %0d samples and %0d checked results over %0d register writes,",
             samples_sent, results_seen, reg_writes);
    $display("with bypass, pole and stage-count extremes and random handshake stalls.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/chp_pkg.sv
rtl/cascaded_complex_highpass_top.sv
tb/tb_top.sv
